>>> hw/rtl/color_ramp_lerp_defines.svh
// Assertion macros used by the color ramp top level.
`ifndef COLOR_RAMP_LERP_DEFINES_SVH
`define COLOR_RAMP_LERP_DEFINES_SVH

`ifndef SYNTH

// Checks a property on every rising clock edge outside reset.
`define CRL_ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: %m");

// Checks that at most one bit of a vector is high on every edge outside reset.
`define CRL_ASSERT_ONEHOT0(lbl, clk, rst_n, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(sig)) \
    else $error("more than one bit set: %m");

`else

`define CRL_ASSERT_PROP(lbl, clk, rst_n, prop)
`define CRL_ASSERT_ONEHOT0(lbl, clk, rst_n, sig)

`endif

`endif

>>> hw/rtl/crl_pkg.sv
// Types, constants and controller/datapath interface for the color ramp.
package crl_pkg;

  localparam int MaxKeysDef = 16;

  // The blend fraction has eight fraction bits and reaches 256 at most.
  localparam int FracW    = 9;
  localparam int DivSteps = FracW;
  localparam int StepW    = 4;
  localparam logic [FracW-1:0] FracFull = 9'd256;

  typedef struct packed {
    logic        kind;
    logic [3:0]  key_index;
    logic [15:0] key_time;
    logic [7:0]  key_red;
    logic [7:0]  key_green;
    logic [7:0]  key_blue;
    logic [7:0]  key_alpha;
    logic [15:0] total_life;
    logic [15:0] life_left;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       blended;
  } out_item_t;

  typedef struct packed {
    logic [15:0] time_v;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
  } key_t;

  typedef enum logic {
    KindKeyWrite = 1'b0,
    KindQuery    = 1'b1
  } kind_e;

  typedef struct packed {
    logic key_write;
    logic start;
    logic read;
    logic advance;
    logic div_start;
    logic div_step;
    logic load_end;
    logic load_blend;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic hit;
    logic first;
    logic last;
    logic div_last;
  } status_t;

endpackage

>>> hw/rtl/crl_ctrl.sv
// Sequencer for key writes, key search, fraction division and result hand-off.
module crl_ctrl
  import crl_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    kind_i,
  output logic    in_ready_o,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StRead  = 5'b00010,
    StCheck = 5'b00100,
    StDiv   = 5'b01000,
    StBlend = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (kind_i == KindKeyWrite) begin
            cmd_o.key_write = 1'b1;
          end else if (!status_i.cnt_zero) begin
            cmd_o.start = 1'b1;
            state_d     = StRead;
          end
        end
      end
      StRead: begin
        cmd_o.read = 1'b1;
        state_d    = StCheck;
      end
      StCheck: begin
        if (status_i.hit && !status_i.first) begin
          cmd_o.div_start = 1'b1;
          state_d         = StDiv;
        end else if (status_i.hit || status_i.last) begin
          // The first or the last key is given as it stands.
          if (out_free) begin
            cmd_o.load_end = 1'b1;
            out_valid_d    = 1'b1;
            state_d        = StIdle;
          end
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = StRead;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = StBlend;
        end
      end
      StBlend: begin
        if (out_free) begin
          cmd_o.load_blend = 1'b1;
          out_valid_d      = 1'b1;
          state_d          = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/crl_dpath.sv
// Key table, age and search registers, serial divider and channel blend.
module crl_dpath
  import crl_pkg::*;
#(
  parameter int MAX_KEYS = MaxKeysDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  input  in_item_t  in_item_i,
  input  cmd_t      cmd_i,
  output status_t   status_o,
  output out_item_t res_o
);

  localparam int IdxW = $clog2(MAX_KEYS);
  localparam int CntW = $clog2(MAX_KEYS + 1);

  key_t              mem [MAX_KEYS];
  logic [4:0]        seg_q;
  logic [15:0]       age_q;
  logic [CntW-1:0]   cnt_q;
  logic [IdxW-1:0]   idx_q;
  key_t              cur_q;
  key_t              prev_q;
  logic [16:0]       rem_q;
  logic [15:0]       span_q;
  logic [FracW-1:0]  quo_q;
  logic [StepW-1:0]  step_q;
  logic              sat_q;
  out_item_t         res_q;

  logic              slot_ok;
  logic [IdxW-1:0]   waddr;
  key_t              wentry;
  logic [CntW-1:0]   cnt_clamp;
  logic [15:0]       age_calc;
  logic [15:0]       off;
  logic              rem_ge;
  logic [16:0]       rem_sub;
  logic [FracW-1:0]  frac;

  function automatic logic [7:0] lerp_chan(input logic [7:0] c0, input logic [7:0] c1,
                                           input logic [FracW-1:0] p);
    logic signed [9:0]  diff;
    logic signed [9:0]  ps;
    logic signed [19:0] prod;
    logic signed [19:0] acc;
    diff = $signed({2'b00, c1}) - $signed({2'b00, c0});
    ps   = $signed({1'b0, p});
    prod = diff * ps;
    acc  = $signed({4'b0000, c0, 8'h00}) + prod;
    return acc[15:8];
  endfunction

  assign slot_ok   = 32'(in_item_i.key_index) < MAX_KEYS;
  assign waddr     = IdxW'(in_item_i.key_index);
  assign wentry    = '{time_v: in_item_i.key_time, red: in_item_i.key_red,
                       green: in_item_i.key_green, blue: in_item_i.key_blue,
                       alpha: in_item_i.key_alpha};
  assign cnt_clamp = (32'(seg_q) > MAX_KEYS) ? CntW'(MAX_KEYS) : CntW'(seg_q);
  assign age_calc  = (in_item_i.total_life > in_item_i.life_left) ?
                     (in_item_i.total_life - in_item_i.life_left) : 16'd0;
  assign off       = (age_q > prev_q.time_v) ? (age_q - prev_q.time_v) : 16'd0;

  // One restoring division step: the remainder always stays below twice the span.
  assign rem_ge  = rem_q >= {1'b0, span_q};
  assign rem_sub = rem_ge ? (rem_q - {1'b0, span_q}) : rem_q;
  assign frac    = sat_q ? FracFull : ((quo_q > FracFull) ? FracFull : quo_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_write && slot_ok) begin
      mem[waddr] <= wentry;
    end
    if (cmd_i.read) begin
      cur_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= '0;
    end else if (cfg_we_i) begin
      seg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      age_q <= age_calc;
      cnt_q <= cnt_clamp;
      idx_q <= '0;
    end
    if (cmd_i.advance) begin
      prev_q <= cur_q;
      idx_q  <= IdxW'(idx_q + IdxW'(1));
    end
    if (cmd_i.div_start) begin
      span_q <= cur_q.time_v - prev_q.time_v;
      sat_q  <= cur_q.time_v <= prev_q.time_v;
      rem_q  <= {1'b0, off};
      quo_q  <= '0;
      step_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= {rem_sub[15:0], 1'b0};
      quo_q  <= {quo_q[FracW-2:0], rem_ge};
      step_q <= StepW'(step_q + StepW'(1));
    end
    if (cmd_i.load_end) begin
      res_q <= '{red: cur_q.red, green: cur_q.green, blue: cur_q.blue,
                 alpha: cur_q.alpha, blended: 1'b0};
    end
    if (cmd_i.load_blend) begin
      res_q <= '{red:   lerp_chan(prev_q.red,   cur_q.red,   frac),
                 green: lerp_chan(prev_q.green, cur_q.green, frac),
                 blue:  lerp_chan(prev_q.blue,  cur_q.blue,  frac),
                 alpha: lerp_chan(prev_q.alpha, cur_q.alpha, frac),
                 blended: 1'b1};
    end
  end

  assign status_o.cnt_zero = (seg_q == '0);
  assign status_o.hit      = (age_q <= cur_q.time_v);
  assign status_o.first    = (idx_q == '0);
  assign status_o.last     = (CntW'(CntW'(idx_q) + CntW'(1)) == cnt_q);
  assign status_o.div_last = (step_q == StepW'(DivSteps - 1));

  assign res_o = res_q;

endmodule

>>> hw/rtl/color_ramp_lerp.sv
// A key write, or a query while the count is zero, is accepted in the idle state and the
// controller stays idle. A query then visits keys in the search with one read state and
// one compare state per key, and when it blends two keys it adds 9 divider steps and one
// blend state. Its result is registered in the output register; the next item is taken
// once the controller is back in idle, which waits while the output register holds a result.
// Reset clears the count, state machine and output valid; keys stay undefined until written.
`include "color_ramp_lerp_defines.svh"

module color_ramp_lerp
  import crl_pkg::*;
#(
  parameter int MAX_KEYS = MaxKeysDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_item_o
);

  cmd_t       cmd;
  status_t    status;
  logic [3:0] action_vec;

  crl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (in_item_i.kind),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  crl_dpath #(
    .MAX_KEYS (MAX_KEYS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_o       (out_item_o)
  );

  assign action_vec = {cmd.advance, cmd.div_start, cmd.load_end, cmd.load_blend};

  `CRL_ASSERT_ONEHOT0(a_one_action, clk_i, rst_ni, action_vec)
  `CRL_ASSERT_PROP(a_div_busy, clk_i, rst_ni, cmd.div_step |-> !in_ready_o)
  `CRL_ASSERT_PROP(a_div_stops, clk_i, rst_ni, (cmd.div_step && status.div_last) |=> !cmd.div_step)
  `CRL_ASSERT_PROP(a_result_after_work, clk_i, rst_ni, $rose(out_valid_o) |-> !$past(in_ready_o))

endmodule

>>> test/tb_color_ramp_lerp.sv
// Self-checking testbench for the color ramp: key writes and particle color queries.
module tb_color_ramp_lerp;
  import crl_pkg::*;

  localparam int unsigned DrainCycles = 48;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned PhaseItems  = 46;

  typedef enum logic {RowItem, RowCount} row_e;
  typedef enum logic [1:0] {WantModel, WantTyped, WantNone} want_e;

  typedef struct {
    row_e        op;
    want_e       src;
    in_item_t    item;
    out_item_t   want;
    int unsigned count;
  } ramp_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_item;

  key_t        ramp_keys [MaxKeysDef];
  int unsigned key_count = 0;
  out_item_t   color_q [$];
  ramp_row_t   rows [$];

  int unsigned err_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 85;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;

  color_ramp_lerp uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] blend_chan(input logic [7:0] c0, input logic [7:0] c1,
                                            input int unsigned p);
    int unsigned sum;
    sum = int'(c1) * p + int'(c0) * (256 - p);
    return 8'(sum >> 8);
  endfunction

  // Updates the key table on a key write; returns 1 with the color when a query yields one.
  function automatic bit ramp_color(input in_item_t it, output out_item_t col);
    int unsigned n, age, i, p, off, span;
    key_t k0, k1;
    col = '0;
    if (it.kind == KindKeyWrite) begin
      ramp_keys[it.key_index].time_v = it.key_time;
      ramp_keys[it.key_index].red    = it.key_red;
      ramp_keys[it.key_index].green  = it.key_green;
      ramp_keys[it.key_index].blue   = it.key_blue;
      ramp_keys[it.key_index].alpha  = it.key_alpha;
      return 1'b0;
    end
    n = (key_count > MaxKeysDef) ? MaxKeysDef : key_count;
    if (n == 0) return 1'b0;
    age = (it.total_life > it.life_left) ? int'(it.total_life) - int'(it.life_left) : 0;
    i = 0;
    while (i < n && age > ramp_keys[i].time_v) i++;
    if (n == 1 || i == 0 || i >= n) begin
      k0 = (n == 1 || i == 0) ? ramp_keys[0] : ramp_keys[n-1];
      col.red     = k0.red;
      col.green   = k0.green;
      col.blue    = k0.blue;
      col.alpha   = k0.alpha;
      col.blended = 1'b0;
    end else begin
      k0 = ramp_keys[i-1];
      k1 = ramp_keys[i];
      if (k1.time_v <= k0.time_v) begin
        p = 256;
      end else begin
        span = int'(k1.time_v) - int'(k0.time_v);
        off  = (age > k0.time_v) ? age - int'(k0.time_v) : 0;
        p    = (off * 256) / span;
        if (p > 256) p = 256;
      end
      col.red     = blend_chan(k0.red, k1.red, p);
      col.green   = blend_chan(k0.green, k1.green, p);
      col.blue    = blend_chan(k0.blue, k1.blue, p);
      col.alpha   = blend_chan(k0.alpha, k1.alpha, p);
      col.blended = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic out_item_t rgba(input int unsigned r, input int unsigned g,
                                     input int unsigned b, input int unsigned a,
                                     input bit bl);
    return {8'(r), 8'(g), 8'(b), 8'(a), bl};
  endfunction

  function automatic void row_key(input int unsigned slot, input int unsigned t,
                                  input out_item_t c);
    ramp_row_t row;
    row = '{RowItem, WantModel, '0, '0, 0};
    row.item.kind      = KindKeyWrite;
    row.item.key_index = 4'(slot);
    row.item.key_time  = 16'(t);
    row.item.key_red   = c.red;
    row.item.key_green = c.green;
    row.item.key_blue  = c.blue;
    row.item.key_alpha = c.alpha;
    rows = {rows, row};
  endfunction

  function automatic void row_query(input int unsigned total, input int unsigned left,
                                    input want_e src, input out_item_t want);
    ramp_row_t row;
    row = '{RowItem, src, '0, want, 0};
    row.item.kind       = KindQuery;
    row.item.total_life = 16'(total);
    row.item.life_left  = 16'(left);
    rows = {rows, row};
  endfunction

  function automatic void row_count(input int unsigned n);
    ramp_row_t row;
    row = '{RowCount, WantNone, '0, '0, n};
    rows = {rows, row};
  endfunction

  // Offers one item, holds it until accepted and records the color it should yield.
  task automatic send_item(input in_item_t it, input want_e src, input out_item_t want);
    out_item_t col;
    bit has_col;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has_col = ramp_color(it, col);
    case (src)
      WantModel: if (has_col) color_q = {color_q, col};
      WantTyped: color_q = {color_q, want};
      default: ;
    endcase
    @(negedge clk);
  endtask

  // The count register is only written once every result is out and the block is quiet.
  task automatic set_key_count(input int unsigned n);
    in_valid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= 5'(n);
    @(negedge clk);
    cfg_we    <= 1'b0;
    key_count = n;
  endtask

  task automatic run_phase(input int unsigned n, input int unsigned items, input bit hold);
    int unsigned slots, t, i, s, lo, hi, top, age, left;
    logic [95:0] noise;
    in_item_t it;
    set_key_count(n);
    if (hold) hold_req = HoldCycles;
    slots = (n > MaxKeysDef) ? MaxKeysDef : n;
    // Load every slot the search can reach with keys in non-decreasing time order.
    t = $urandom_range(200);
    for (i = 0; i < slots; i++) begin
      noise = {$urandom, $urandom, $urandom};
      it = in_item_t'(noise[$bits(in_item_t)-1:0]);
      it.kind      = KindKeyWrite;
      it.key_index = 4'(i);
      it.key_time  = 16'(t);
      send_item(it, WantModel, '0);
      if ($urandom_range(7) != 0) t = t + $urandom_range(3000, 1);
      if (t > 65535) t = 65535;
    end
    for (i = 0; i < items; i++) begin
      noise = {$urandom, $urandom, $urandom};
      it = in_item_t'(noise[$bits(in_item_t)-1:0]);
      if ($urandom_range(9) < 7) begin
        it.kind = KindQuery;
        if ($urandom_range(9) < 8) begin
          top = 0;
          for (s = 0; s < slots; s++) if (ramp_keys[s].time_v > top) top = ramp_keys[s].time_v;
          top = (top + 64 > 65535) ? 65535 : top + 64;
          age  = $urandom_range(top);
          left = $urandom_range(65535 - age);
          it.total_life = 16'(age + left);
          it.life_left  = 16'(left);
        end
      end else begin
        it.kind = KindKeyWrite;
        // Most key writes refresh a slot without breaking the time order.
        if (slots != 0 && $urandom_range(2) != 0) begin
          s  = $urandom_range(slots - 1);
          lo = (s == 0) ? 0 : ramp_keys[s-1].time_v;
          hi = (s == slots - 1) ? 65535 : ramp_keys[s+1].time_v;
          it.key_index = 4'(s);
          if (hi >= lo) it.key_time = 16'($urandom_range(hi, lo));
        end
      end
      send_item(it, WantModel, '0);
    end
  endtask

  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (color_q.size() == 0) begin
        err_cnt++;
        $display("%0t: color with none expected: got %p", $time, out_item);
      end else begin
        want = color_q.pop_front();
        if (out_item.red !== want.red || out_item.green !== want.green ||
            out_item.blue !== want.blue || out_item.alpha !== want.alpha ||
            out_item.blended !== want.blended) begin
          err_cnt++;
          $display("%0t: color mismatch: expected %p, got %p", $time, want, out_item);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else if (rst_n) quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned ph;
    int unsigned phase_counts [12];
    phase_counts = '{1, 16, 31, 0, 2, 5, 16, 3, 8, 31, 1, 12};

    // Keys: an ordered run, a key out of order, and the two highest slots at the two time extremes.
    row_query(7, 3, WantNone, '0);
    row_key(0, 100, rgba(10, 20, 30, 40, 0));
    row_key(1, 200, rgba(255, 0, 128, 255, 0));
    row_key(2, 1000, rgba(0, 255, 255, 0, 0));
    row_key(3, 50, rgba(1, 2, 3, 4, 0));
    row_key(15, 65535, rgba(255, 255, 255, 255, 0));
    row_key(14, 0, rgba(0, 0, 0, 0, 0));
    row_count(1);
    row_query(0, 0, WantTyped, rgba(10, 20, 30, 40, 0));
    row_query(65535, 0, WantTyped, rgba(10, 20, 30, 40, 0));
    row_count(3);
    row_query(100, 0, WantTyped, rgba(10, 20, 30, 40, 0));
    row_query(5, 65535, WantTyped, rgba(10, 20, 30, 40, 0));
    row_query(150, 0, WantModel, '0);
    row_query(200, 0, WantTyped, rgba(255, 0, 128, 255, 1));
    row_query(700, 100, WantModel, '0);
    row_query(65535, 64534, WantTyped, rgba(0, 255, 255, 0, 0));
    row_count(4);
    row_query(2000, 0, WantTyped, rgba(1, 2, 3, 4, 0));
    row_query(65535, 65535, WantTyped, rgba(10, 20, 30, 40, 0));
    row_query(1000, 0, WantTyped, rgba(0, 255, 255, 0, 1));
    row_query(1, 0, WantModel, '0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (rows[k]) begin
      if (rows[k].op == RowCount) set_key_count(rows[k].count);
      else send_item(rows[k].item, rows[k].src, rows[k].want);
    end

    for (ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 85;
        recv_idle_pct = 38;
      end
      if (ph == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_phase(phase_counts[ph], PhaseItems, ph == 8);
    end

    in_valid <= 1'b0;
    while (color_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (color_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d colors never arrived", $time, color_q.size());
    end
    if (err_cnt == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
